>>> src/jbeq_pkg.sv
// shared types and constants for the joystick and button event queue
// no dependencies
package jbeq_pkg;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int unsigned SAMPLE_W    = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned DROP_W      = 2;
  localparam int unsigned FILL_W      = 4;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [SAMPLE_W-1:0] RIGHT_RST = 14'd10300;
  localparam logic [SAMPLE_W-1:0] LEFT_RST  = 14'd9800;
  localparam logic [SAMPLE_W-1:0] UP_RST    = 14'd12000;
  localparam logic [SAMPLE_W-1:0] DOWN_RST  = 14'd6000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT = 2'd0,
    CFG_LEFT  = 2'd1,
    CFG_UP    = 2'd2,
    CFG_DOWN  = 2'd3
  } cfg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_JOY  = 2'd0,
    REQ_BTN  = 2'd1,
    REQ_POP  = 2'd2,
    REQ_IDLE = 2'd3
  } req_e;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_A     = 3'd5,
    EV_B     = 3'd6
  } ev_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH_B,
    ST_POP
  } state_e;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t next_slot(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QUEUE_SLOTS - 1)) r = '0;
    else r = p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t held(ptr_t wp, ptr_t rp);
    ptr_t r;
    if (wp >= rp) r = wp - rp;
    else r = ptr_t'(QUEUE_SLOTS - 1) - (rp - wp) + ptr_t'(1);
    return r;
  endfunction

endpackage

>>> src/joystick_button_event_queue.sv
// top level: joystick classifier and ring event queue held in one slot memory
// depends on jbeq_pkg
//
// One request word is taken at a time. A joystick sample, a button word with
// flag B clear, an unused request kind or a dequeue from an empty queue is
// finished in the cycle it is accepted. A button word with flag B set goes
// through ST_PUSH_B: A goes in when the word is accepted and B in ST_PUSH_B,
// because the slot memory has one write port. A dequeue from a non-empty queue
// goes through ST_POP because the slot memory has a registered read. The
// result sits in an output register and the next request word is taken in the
// cycle it is drained. The queue holds at most QUEUE_SLOTS-1 events; events
// that find it full are dropped and counted in the result word.
module joystick_button_event_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [jbeq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jbeq_pkg::SAMPLE_W-1:0]      cfg_data_i,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // h_sample[13:0], v_sample[27:14], button_a_flag[28], button_b_flag[29], zero
  input  logic [jbeq_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type[1:0]
  input  logic [jbeq_pkg::REQ_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // event_code[2:0], dropped_count[4:3], fill_level[8:5], zero
  output logic [jbeq_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import jbeq_pkg::*;

  logic [SAMPLE_W-1:0] right_q, left_q, up_q, down_q;
  state_e              state_q, state_d;
  ptr_t                wp_q, wp_d, rp_q, rp_d;
  ev_e                 prev_q, prev_d;
  logic                drop_a_q, drop_a_d;
  logic                ovalid_q;
  logic [CODE_W-1:0]   oev_q, oev_d;
  logic [DROP_W-1:0]   odrop_q, odrop_d;
  logic [FILL_W-1:0]   ofill_q;
  logic                load_out;
  logic                accept;
  logic                mem_we;
  ptr_t                mem_wa;
  logic [CODE_W-1:0]   mem_wd;
  logic [CODE_W-1:0]   mem_q [QUEUE_SLOTS];
  logic [CODE_W-1:0]   rd_q;
  logic [SAMPLE_W-1:0] h_smp, v_smp;
  logic                flag_a, flag_b;
  req_e                req;
  ev_e                 dir;
  logic                full, empty;

  assign h_smp  = s_tdata[SAMPLE_W-1:0];
  assign v_smp  = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign flag_a = s_tdata[2*SAMPLE_W];
  assign flag_b = s_tdata[2*SAMPLE_W+1];
  assign req    = req_e'(s_tuser);

  assign s_tready = (state_q == ST_IDLE) && (!ovalid_q || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign full     = (next_slot(wp_q) == rp_q);
  assign empty    = (wp_q == rp_q);

  always_comb begin
    priority if (h_smp >= right_q) dir = EV_RIGHT;
    else if (h_smp <= left_q)      dir = EV_LEFT;
    else if (v_smp >= up_q)        dir = EV_UP;
    else if (v_smp <= down_q)      dir = EV_DOWN;
    else                           dir = EV_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= RIGHT_RST;
      left_q  <= LEFT_RST;
      up_q    <= UP_RST;
      down_q  <= DOWN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RIGHT: right_q <= cfg_data_i;
        CFG_LEFT:  left_q  <= cfg_data_i;
        CFG_UP:    up_q    <= cfg_data_i;
        CFG_DOWN:  down_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    prev_d   = prev_q;
    drop_a_d = drop_a_q;
    oev_d    = EV_NONE;
    odrop_d  = '0;
    load_out = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = wp_q;
    mem_wd   = EV_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_JOY: begin
              load_out = 1'b1;
              prev_d   = dir;
              if (dir != EV_NONE && dir != prev_q) begin
                if (full) begin
                  odrop_d = DROP_W'(1);
                end else begin
                  mem_we = 1'b1;
                  mem_wd = dir;
                  wp_d   = next_slot(wp_q);
                end
              end
            end
            REQ_BTN: begin
              drop_a_d = 1'b0;
              if (flag_a) begin
                if (full) begin
                  drop_a_d = 1'b1;
                end else begin
                  mem_we = 1'b1;
                  mem_wd = EV_A;
                  wp_d   = next_slot(wp_q);
                end
              end
              if (flag_b) begin
                state_d = ST_PUSH_B;
              end else begin
                load_out = 1'b1;
                odrop_d  = DROP_W'(drop_a_d);
              end
            end
            REQ_POP: begin
              if (empty) begin
                load_out = 1'b1;
              end else begin
                rp_d    = next_slot(rp_q);
                state_d = ST_POP;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_PUSH_B: begin
        load_out = 1'b1;
        state_d  = ST_IDLE;
        if (full) begin
          odrop_d = DROP_W'(drop_a_q) + DROP_W'(1);
        end else begin
          odrop_d = DROP_W'(drop_a_q);
          mem_we  = 1'b1;
          mem_wd  = EV_B;
          wp_d    = next_slot(wp_q);
        end
      end
      ST_POP: begin
        load_out = 1'b1;
        oev_d    = rd_q;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wp_q     <= '0;
      rp_q     <= '0;
      prev_q   <= EV_NONE;
      drop_a_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      prev_q   <= prev_d;
      drop_a_q <= drop_a_d;
      if (load_out) ovalid_q <= 1'b1;
      else if (m_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      oev_q   <= oev_d;
      odrop_q <= odrop_d;
      ofill_q <= FILL_W'(held(wp_d, rp_d));
    end
  end

  // slot memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[rp_q];
  end

  assign m_tvalid = ovalid_q;
  assign m_tdata  = {{(OUT_DATA_W - CODE_W - DROP_W - FILL_W){1'b0}},
                     ofill_q, odrop_q, oev_q};

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !ovalid_q)
    else $error("result word pending while an item is in progress");

  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (wp_q != rp_q))
    else $error("queue empty right after a stored event");

  a_pop_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (ovalid_q && state_q == ST_IDLE))
    else $error("dequeue did not produce a result word");

endmodule
